// ----- sv/tle_pkg.sv -----
// ----------------------------------------------------------------------------
// tle_pkg: shared types and constants of the terminal line editor
// Holds the payload structs, the control state type, the control/status
// structs between the controller and the datapath, and character codes.
// ----------------------------------------------------------------------------
package tle_pkg;

  localparam int BUF_DEPTH = 64;
  localparam int IDX_W     = 6;
  localparam int LEN_W     = 7;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_ESCAPE    = 8'h1B;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  localparam logic [1:0] ESC_SKIP = 2'd2;

  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } tle_req_t;

  typedef struct packed {
    logic [7:0]       char_value;
    logic [IDX_W-1:0] char_index;
    logic             is_last;
    logic             line_dropped;
  } tle_res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD
  } tle_state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept_en;
    logic rd_en;
    logic load_char;
  } tle_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit_start;
    logic out_free;
    logic last_char;
  } tle_status_t;

endpackage

// ----- sv/tle_ctrl.sv -----
// ----------------------------------------------------------------------------
// tle_ctrl: line editor sequencer
// Idles while editing bytes, then walks a committed line out of the buffer,
// one buffer read and one output load per character, each load waiting for a free output register.
// ----------------------------------------------------------------------------
module tle_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tle_pkg::tle_status_t status_i,
  output tle_pkg::tle_cmd_t    cmd_o
);

  tle_pkg::tle_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tle_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tle_pkg::S_IDLE: begin
        if (status_i.emit_start) begin
          state_d = tle_pkg::S_READ;
        end
      end
      tle_pkg::S_READ: begin
        state_d = tle_pkg::S_LOAD;
      end
      tle_pkg::S_LOAD: begin
        if (status_i.out_free) begin
          state_d = status_i.last_char ? tle_pkg::S_IDLE : tle_pkg::S_READ;
        end
      end
      default: begin
        state_d = tle_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      tle_pkg::S_IDLE: begin
        cmd_o.accept_en = status_i.out_free;
      end
      tle_pkg::S_READ: begin
        cmd_o.rd_en = 1'b1;
      end
      tle_pkg::S_LOAD: begin
        cmd_o.load_char = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ----- sv/tle_datapath.sv -----
// ----------------------------------------------------------------------------
// tle_datapath: line buffer, edit state and output register
// Decodes each accepted byte, edits the line buffer, and drives the result
// register for both character runs and dropped-line results.
// ----------------------------------------------------------------------------
module tle_datapath #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  tle_pkg::tle_req_t    in_data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output tle_pkg::tle_res_t    out_data_o,
  input  tle_pkg::tle_cmd_t    cmd_i,
  output tle_pkg::tle_status_t status_o
);

  localparam int EffCap = (LINE_CAPACITY < tle_pkg::BUF_DEPTH) ?
                          LINE_CAPACITY : tle_pkg::BUF_DEPTH;
  localparam logic [tle_pkg::LEN_W-1:0] EffCapLen = tle_pkg::LEN_W'(EffCap);

  logic [7:0] mem_q [tle_pkg::BUF_DEPTH];
  logic [7:0] rdata_q;

  logic [tle_pkg::LEN_W-1:0] len_q, len_d;
  logic [1:0]                skip_q, skip_d;
  logic                      pend_q, pend_d;
  logic [tle_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [tle_pkg::LEN_W-1:0] emit_len_q, emit_len_d;
  logic                      out_valid_q, out_valid_d;
  tle_pkg::tle_res_t         out_q, out_d;

  logic       fire;
  logic [7:0] ch_fold;
  logic       wr_en;
  logic       drop_load;
  logic       emit_go;
  logic       can_store;
  logic       last_char;
  logic       out_free;

  assign fire      = in_valid_i && cmd_i.accept_en;
  assign can_store = (len_q < EffCapLen);
  assign out_free  = !out_valid_q || out_ready_i;
  assign last_char = ({1'b0, idx_q} + tle_pkg::LEN_W'(1)) == emit_len_q;

  // fold upper case to lower case
  always_comb begin
    ch_fold = in_data_i.rx_byte;
    if (in_data_i.rx_byte inside {[tle_pkg::CH_UPPER_A:tle_pkg::CH_UPPER_Z]}) begin
      ch_fold = in_data_i.rx_byte + tle_pkg::CASE_OFFSET;
    end
  end

  always_comb begin
    len_d     = len_q;
    skip_d    = skip_q;
    pend_d    = pend_q;
    wr_en     = 1'b0;
    drop_load = 1'b0;
    emit_go   = 1'b0;
    if (fire) begin
      if (in_data_i.req_type == tle_pkg::REQ_RELEASE) begin
        pend_d = 1'b0;
      end else if (skip_q != 2'd0) begin
        skip_d = skip_q - 2'd1;
      end else begin
        case (ch_fold)
          tle_pkg::CH_BACKSPACE: begin
            if (len_q != '0) begin
              len_d = len_q - tle_pkg::LEN_W'(1);
            end
          end
          tle_pkg::CH_ESCAPE: begin
            skip_d = tle_pkg::ESC_SKIP;
          end
          tle_pkg::CH_LF: begin
          end
          tle_pkg::CH_CR: begin
            if (len_q != '0) begin
              if (pend_q) begin
                drop_load = 1'b1;
              end else begin
                emit_go = 1'b1;
                pend_d  = 1'b1;
              end
              len_d = '0;
            end
          end
          tle_pkg::CH_TAB, tle_pkg::CH_SPACE: begin
            // drop leading blanks
            if (len_q != '0 && can_store) begin
              wr_en = 1'b1;
              len_d = len_q + tle_pkg::LEN_W'(1);
            end
          end
          default: begin
            if (can_store) begin
              wr_en = 1'b1;
              len_d = len_q + tle_pkg::LEN_W'(1);
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    idx_d      = idx_q;
    emit_len_d = emit_len_q;
    if (emit_go) begin
      idx_d      = '0;
      emit_len_d = len_q;
    end else if (cmd_i.load_char && !last_char) begin
      idx_d = idx_q + tle_pkg::IDX_W'(1);
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (drop_load) begin
      out_d.char_value   = '0;
      out_d.char_index   = '0;
      out_d.is_last      = 1'b1;
      out_d.line_dropped = 1'b1;
      out_valid_d        = 1'b1;
    end else if (cmd_i.load_char) begin
      out_d.char_value   = rdata_q;
      out_d.char_index   = idx_q;
      out_d.is_last      = last_char;
      out_d.line_dropped = 1'b0;
      out_valid_d        = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[len_q[tle_pkg::IDX_W-1:0]] <= ch_fold;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      skip_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      skip_q      <= skip_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    emit_len_q <= emit_len_d;
    out_q      <= out_d;
  end

  assign out_valid_o         = out_valid_q;
  assign out_data_o          = out_q;
  assign status_o.emit_start = emit_go;
  assign status_o.out_free   = out_free;
  assign status_o.last_char  = last_char;

  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= EffCapLen)
    else $error("line length beyond capacity");

  a_skip_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q <= tle_pkg::ESC_SKIP)
    else $error("skip count beyond escape length");

  a_emit_marks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |=> (pend_q && len_q == '0))
    else $error("emitted line not marked pending or buffer not restarted");

  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_char |-> ({1'b0, idx_q} < emit_len_q))
    else $error("character index past committed length");

  a_no_edit_in_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rd_en || cmd_i.load_char) |-> !fire)
    else $error("input transfer during line emission");

endmodule

// ----- sv/terminal_line_editor.sv -----
// ----------------------------------------------------------------------------
// terminal_line_editor: serial terminal command line assembler
// Edits received bytes into a command line and emits each completed line as
// a run of characters, or a dropped result while a line is still pending.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------
//   in      | input     | in_valid_i / in_ready_o | tle_req_t (req, byte)
//   out     | output    | out_valid_o / out_ready_i | tle_res_t (one char)
//
// Edit bytes and releases are accepted back to back while the editor idles
// and the output register is free or being drained.
// A committed line is emitted with one buffer read and one output register
// load per character, as the line buffer has a single read port.
// Input is held off during emission and while a full output register stalls.
// Reset clears length, skip count, pending mark and output valid; the line
// buffer needs no clearing.
// ----------------------------------------------------------------------------
module terminal_line_editor #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tle_pkg::tle_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tle_pkg::tle_res_t out_data_o
);

  tle_pkg::tle_cmd_t    cmd;
  tle_pkg::tle_status_t status;

  tle_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  tle_datapath #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  assign in_ready_o = cmd.accept_en;

endmodule

// ----- tb/tb_terminal_line_editor.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_terminal_line_editor: self-checking bench for the terminal line editor
// Feeds edit bytes and release requests through the input channel. It rebuilds
// the edit line, skip count and pending mark alongside the block and checks
// every emitted character or dropped-line result in order. Sender gaps and
// receiver stalls vary by phase, and one phase holds the output off at length.
// ----------------------------------------------------------------------------
module tb_terminal_line_editor;

  localparam int LINE_CAP        = 64;
  localparam int CAP_EFF         = (LINE_CAP < tle_pkg::BUF_DEPTH) ?
                                   LINE_CAP : tle_pkg::BUF_DEPTH;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int TAIL_CYCLES     = 20;
  localparam int MAX_REPORTS     = 20;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  tle_pkg::tle_req_t in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  tle_pkg::tle_res_t out_data_o;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_off_req   = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned items_sent     = 0;
  int unsigned quiet_cycles   = 0;

  class line_scoreboard;
    logic [7:0]        line_buf [tle_pkg::BUF_DEPTH];
    int unsigned       line_len   = 0;
    int unsigned       skip_left  = 0;
    bit                pending    = 1'b0;
    tle_pkg::tle_res_t expected_chars[$];
    int unsigned       errors     = 0;
    int unsigned       n_inputs   = 0;
    int unsigned       n_results  = 0;
    int unsigned       n_lines    = 0;
    int unsigned       n_dropped  = 0;
    int unsigned       n_full     = 0;

    function void store_char(logic [7:0] ch);
      if (line_len < CAP_EFF) begin
        line_buf[line_len] = ch;
        line_len++;
      end else begin
        n_full++;
      end
    endfunction

    // Advance the edit state by one accepted transfer and queue its results.
    function void note_input(tle_pkg::tle_req_t req);
      logic [7:0]        ch;
      tle_pkg::tle_res_t res;
      n_inputs++;
      if (req.req_type == tle_pkg::REQ_RELEASE) begin
        pending = 1'b0;
        return;
      end
      if (skip_left != 0) begin
        skip_left--;
        return;
      end
      ch = req.rx_byte;
      if (ch >= tle_pkg::CH_UPPER_A && ch <= tle_pkg::CH_UPPER_Z)
        ch = ch + tle_pkg::CASE_OFFSET;
      case (ch)
        tle_pkg::CH_BACKSPACE: begin
          if (line_len > 0) line_len--;
        end
        tle_pkg::CH_ESCAPE: begin
          skip_left = tle_pkg::ESC_SKIP;
        end
        tle_pkg::CH_LF: begin
        end
        tle_pkg::CH_CR: begin
          if (line_len != 0) begin
            if (pending) begin
              res.char_value   = 8'h00;
              res.char_index   = '0;
              res.is_last      = 1'b1;
              res.line_dropped = 1'b1;
              expected_chars.push_back(res);
              n_dropped++;
            end else begin
              for (int i = 0; i < line_len; i++) begin
                res.char_value   = line_buf[i];
                res.char_index   = tle_pkg::IDX_W'(i);
                res.is_last      = (i + 1 == line_len);
                res.line_dropped = 1'b0;
                expected_chars.push_back(res);
              end
              pending = 1'b1;
              n_lines++;
            end
            line_len = 0;
          end
        end
        tle_pkg::CH_TAB, tle_pkg::CH_SPACE: begin
          // drop leading blanks
          if (line_len != 0) store_char(ch);
        end
        default: begin
          store_char(ch);
        end
      endcase
    endfunction

    function void field_mismatch(string field, logic [7:0] want, logic [7:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: mismatch on %s: expected 0x%02h, actual 0x%02h",
                 $time, field, want, got);
    endfunction

    function void check_result(tle_pkg::tle_res_t got);
      tle_pkg::tle_res_t want;
      n_results++;
      if (expected_chars.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result: expected none, actual %p", $time, got);
        return;
      end
      want = expected_chars.pop_front();
      if (got.char_value !== want.char_value)
        field_mismatch("char_value", want.char_value, got.char_value);
      if (got.char_index !== want.char_index)
        field_mismatch("char_index", 8'(want.char_index), 8'(got.char_index));
      if (got.is_last !== want.is_last)
        field_mismatch("is_last", 8'(want.is_last), 8'(got.is_last));
      if (got.line_dropped !== want.line_dropped)
        field_mismatch("line_dropped", 8'(want.line_dropped), 8'(got.line_dropped));
    endfunction
  endclass

  line_scoreboard line_sb = new();

  terminal_line_editor #(
    .LINE_CAPACITY(LINE_CAP)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Check results before noting inputs; a result never stems from a transfer
  // accepted at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) line_sb.check_result(out_data_o);
      if (in_valid_i && in_ready_o) line_sb.note_input(in_data_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, giving up", $time, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, or a long hold-off counted here once requested.
  always @(negedge clk_i) begin
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left    = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input tle_pkg::tle_req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] ch);
    tle_pkg::tle_req_t item;
    item.req_type = tle_pkg::REQ_BYTE;
    item.rx_byte  = ch;
    send_item(item);
  endtask

  task automatic send_release();
    tle_pkg::tle_req_t item;
    item.req_type = tle_pkg::REQ_RELEASE;
    item.rx_byte  = 8'($urandom_range(255));
    send_item(item);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (line_sb.expected_chars.size() != 0) @(negedge clk_i);
  endtask

  // Mostly short lines, some long, a few past the capacity.
  task automatic send_random_line();
    int len;
    int pick;
    pick = $urandom_range(99);
    if (pick < 85) len = $urandom_range(12);
    else if (pick < 95) len = $urandom_range(40, 13);
    else len = $urandom_range(75, 60);
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(99);
      if (pick < 68) begin
        send_byte(8'($urandom_range(8'h7E, 8'h21)));
      end else if (pick < 78) begin
        send_byte(8'($urandom_range(255)));
      end else if (pick < 84) begin
        send_byte(tle_pkg::CH_BACKSPACE);
      end else if (pick < 88) begin
        send_byte(tle_pkg::CH_SPACE);
      end else if (pick < 90) begin
        send_byte(tle_pkg::CH_TAB);
      end else if (pick < 94) begin
        send_byte(tle_pkg::CH_ESCAPE);
        send_byte(8'($urandom_range(255)));
        send_byte(8'($urandom_range(255)));
      end else if (pick < 97) begin
        send_byte(tle_pkg::CH_LF);
      end else begin
        send_release();
      end
    end
    if ($urandom_range(99) < 90) send_byte(tle_pkg::CH_CR);
    if ($urandom_range(99) < 60) send_release();
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned target;
    target = items_sent + n_items;
    while (items_sent < target) send_random_line();
  endtask

  task automatic run_directed();
    send_release();                      // nothing pending
    send_byte(tle_pkg::CH_CR);           // empty line
    send_byte(tle_pkg::CH_BACKSPACE);    // empty line
    send_byte(tle_pkg::CH_SPACE);        // leading blank
    send_byte(tle_pkg::CH_TAB);          // leading blank
    send_byte(tle_pkg::CH_LF);
    send_byte(tle_pkg::CH_UPPER_A);
    send_byte(tle_pkg::CH_UPPER_Z);
    send_byte(8'h40);                    // just below the upper-case range
    send_byte(8'h5B);                    // just above it
    send_byte(tle_pkg::CH_TAB);
    send_byte(tle_pkg::CH_SPACE);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(tle_pkg::CH_BACKSPACE);
    send_byte(tle_pkg::CH_ESCAPE);       // skip a carriage return and an escape
    send_byte(tle_pkg::CH_CR);
    send_byte(tle_pkg::CH_ESCAPE);
    send_byte(8'h71);
    send_byte(tle_pkg::CH_CR);           // emit the line
    send_byte(8'h78);
    send_byte(tle_pkg::CH_CR);           // still pending: dropped
    send_release();
    send_byte(8'h79);
    send_byte(tle_pkg::CH_CR);
    send_release();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();
    wait_drained();

    // No idling; hold the output off while a long line and more bytes arrive.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_release();
    hold_off_req = 1'b1;
    for (int k = 0; k < 30; k++) send_byte(8'($urandom_range(8'h7A, 8'h61)));
    send_byte(tle_pkg::CH_CR);
    run_random(40);
    wait_drained();

    send_idle_pct  = 48;
    recv_stall_pct = 0;
    run_random(75);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 48;
    run_random(75);
    wait_drained();

    send_idle_pct  = 19;
    recv_stall_pct = 19;
    run_random(75);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Run covered %0d input transfers and %0d result transfers.",
             line_sb.n_inputs, line_sb.n_results);
    $display("Lines emitted: %0d, lines dropped: %0d, bytes refused on a full line: %0d.",
             line_sb.n_lines, line_sb.n_dropped, line_sb.n_full);
    if (line_sb.errors == 0 && line_sb.expected_chars.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived",
               line_sb.errors, line_sb.expected_chars.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
